### hw/rtl/wtip_pkg.sv
// ----------------------------------------------------------------------------
// wtip_pkg
// Shared types and constants of the wavetable interpolating player.
// ----------------------------------------------------------------------------
package wtip_pkg;

  // default sizes, handed to the top level parameters
  localparam int ADDR_BITS_DEF   = 12;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int POS_W  = 32;
  localparam int GAIN_W = 16;
  localparam int SPM_W  = 24;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 4;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;
  localparam logic [SPM_W-1:0]  SPM_RST  = 24'd3145728;
  localparam logic [LEN_W-1:0]  LEN_RST  = 4'd12;

  // position units
  typedef enum logic [1:0] {
    MODE_SAMPLES = 2'd0,
    MODE_MSEC    = 2'd1,
    MODE_NORM    = 2'd2,
    MODE_FAST    = 2'd3
  } mode_t;

  // register map, index is paddr[3:2]
  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_GAIN = 2'd1,
    REG_SPM  = 2'd2,
    REG_LEN  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PLAY  = 1'b1
  } op_t;

endpackage

### hw/rtl/wavetable_interp_player.sv
// ----------------------------------------------------------------------------
// wavetable_interp_player
// Power-of-two sample table with linear interpolation, gain and saturation,
// or a plain truncated table lookup in fast mode.
// Input beats carry an op: a write stores in_table_data at in_table_addr, a
// play reads the table at in_position (signed Q16.16) in the unit chosen by
// the mode register and returns one out_sample beat. Writes return nothing.
// Plays and writes keep their order, so a play sees every earlier write.
// The pipeline has seven register stages: input, position multiply, index and
// clip, table read, interpolation multiplies, gain multiply, round/saturate
// into the output register, from which a play beat shows on out_valid. One
// beat can be accepted every cycle unless a waiting result holds the pipeline.
// When out_valid is high and out_ready low, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Registers sit on an APB port (mode, gain, samples per ms, length log2 at
// byte addresses 0, 4, 8, 12); write them only while the pipeline is empty.
// rst_n (synchronous) empties the pipeline and loads register defaults; the
// table keeps no reset and holds garbage until written.
// ----------------------------------------------------------------------------
module wavetable_interp_player #(
  parameter int ADDR_BITS   = wtip_pkg::ADDR_BITS_DEF,
  parameter int SAMPLE_BITS = wtip_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [ADDR_BITS-1:0]             in_table_addr,
  input  logic signed [SAMPLE_BITS-1:0]    in_table_data,
  input  logic signed [wtip_pkg::POS_W-1:0] in_position,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]    out_sample,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wtip_pkg::PADDR_W-1:0]     paddr,
  input  logic [wtip_pkg::DATA_W-1:0]      pwdata,
  output logic [wtip_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int DEPTH  = 1 << ADDR_BITS;
  localparam int LG_W   = $clog2(ADDR_BITS + 1);
  localparam int POS_W  = wtip_pkg::POS_W;
  localparam int SPM_W  = wtip_pkg::SPM_W;
  localparam int GAIN_W = wtip_pkg::GAIN_W;
  localparam int PW     = POS_W + SPM_W + 1;
  localparam int SH_W   = POS_W + ADDR_BITS;
  localparam int XC_W   = ADDR_BITS + 17;
  localparam int MW     = SAMPLE_BITS + 18;
  localparam int SW     = MW + 1;
  localparam int VW     = SW + GAIN_W + 1;
  localparam int RW     = VW - 28;
  localparam logic signed [VW-1:0] RND = VW'(1) <<< 27;

  // configuration registers
  wtip_pkg::mode_t             mode_r;
  logic [GAIN_W-1:0]           gain_r;
  logic [SPM_W-1:0]            spm_r;
  logic [wtip_pkg::LEN_W-1:0]  len_log2_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= wtip_pkg::MODE_NORM;
      gain_r     <= wtip_pkg::GAIN_RST;
      spm_r      <= wtip_pkg::SPM_RST;
      len_log2_r <= wtip_pkg::LEN_RST;
    end else if (cfg_wr) begin
      unique case (wtip_pkg::reg_idx_t'(paddr[3:2]))
        wtip_pkg::REG_MODE: mode_r     <= wtip_pkg::mode_t'(pwdata[1:0]);
        wtip_pkg::REG_GAIN: gain_r     <= pwdata[GAIN_W-1:0];
        wtip_pkg::REG_SPM:  spm_r      <= pwdata[SPM_W-1:0];
        wtip_pkg::REG_LEN:  len_log2_r <= pwdata[wtip_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wtip_pkg::reg_idx_t'(paddr[3:2]))
      wtip_pkg::REG_MODE: prdata = wtip_pkg::DATA_W'(mode_r);
      wtip_pkg::REG_GAIN: prdata = wtip_pkg::DATA_W'(gain_r);
      wtip_pkg::REG_SPM:  prdata = wtip_pkg::DATA_W'(spm_r);
      wtip_pkg::REG_LEN:  prdata = wtip_pkg::DATA_W'(len_log2_r);
      default:            prdata = '0;
    endcase
  end

  // effective table length
  logic [LG_W-1:0]      lg;
  logic [ADDR_BITS-1:0] lmask;

  always_comb begin
    if (int'(len_log2_r) > ADDR_BITS) begin
      lg = LG_W'(ADDR_BITS);
    end else begin
      lg = LG_W'(len_log2_r);
    end
    for (int k = 0; k < ADDR_BITS; k++) begin
      lmask[k] = (k < int'(lg));
    end
  end

  // pipeline advances unless a result waits at the output
  logic en;
  logic out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1: input register
  logic                          play1_r;
  logic [ADDR_BITS-1:0]          addr1_r;
  logic signed [SAMPLE_BITS-1:0] data1_r;
  logic signed [POS_W-1:0]       pos1_r;

  // stage 2: position products
  logic                          play2_r;
  logic [ADDR_BITS-1:0]          addr2_r;
  logic signed [SAMPLE_BITS-1:0] data2_r;
  logic signed [POS_W-1:0]       pos2_r;
  logic signed [PW-1:0]          prod2_r;
  logic signed [SH_W-1:0]        sh2_r;

  // stage 3: indices and fraction
  logic                          play3_r;
  logic                          fast3_r;
  logic [ADDR_BITS-1:0]          addr3_r;
  logic signed [SAMPLE_BITS-1:0] data3_r;
  logic [ADDR_BITS-1:0]          i0_3_r;
  logic [ADDR_BITS-1:0]          i1_3_r;
  logic [15:0]                   f3_r;

  // stage 4: table read
  logic                          play4_r;
  logic                          fast4_r;
  logic [15:0]                   f4_r;
  logic signed [SAMPLE_BITS-1:0] t0_4_r;
  logic signed [SAMPLE_BITS-1:0] t1_4_r;

  // stage 5: weighted taps
  logic                          play5_r;
  logic                          fast5_r;
  logic signed [SAMPLE_BITS-1:0] t5_r;
  logic signed [MW-1:0]          m0_5_r;
  logic signed [MW-1:0]          m1_5_r;

  // stage 6: gained sum
  logic                          play6_r;
  logic                          fast6_r;
  logic signed [SAMPLE_BITS-1:0] t6_r;
  logic signed [VW-1:0]          gsum6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r && play6_r;
    end
  end

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  // stage 3 logic
  logic signed [PW-1:0]  x;
  logic [PW-1:0]         lim;
  logic [PW-1:0]         xcl;
  logic [XC_W-1:0]       xc;
  logic [ADDR_BITS-1:0]  i0_lin;
  logic [ADDR_BITS-1:0]  i0_fast;
  logic [ADDR_BITS-1:0]  i0;
  logic [ADDR_BITS-1:0]  i1;
  logic                  trunc_fix;
  logic                  fast;

  always_comb begin
    fast = (mode_r == wtip_pkg::MODE_FAST);
    unique case (mode_r)
      wtip_pkg::MODE_SAMPLES: x = {{(PW-POS_W){pos2_r[POS_W-1]}}, pos2_r};
      // negative product counts as zero
      wtip_pkg::MODE_MSEC: begin
        if (prod2_r[PW-1]) begin
          x = '0;
        end else begin
          x = {16'b0, prod2_r[PW-1:16]};
        end
      end
      default: x = {{(PW-SH_W){sh2_r[SH_W-1]}}, sh2_r};
    endcase
    lim = {{(PW-1){1'b0}}, 1'b1} << (32'(lg) + 32'd16);
    if (x[PW-1]) begin
      xcl = '0;
    end else if (x > $signed(lim)) begin
      xcl = lim;
    end else begin
      xcl = x;
    end
    xc     = xcl[XC_W-1:0];
    i0_lin = xc[ADDR_BITS+15:16] & lmask;
    // fast mode truncates toward zero
    trunc_fix = sh2_r[SH_W-1] && (sh2_r[15:0] != 16'd0);
    i0_fast   = (sh2_r[ADDR_BITS+15:16] + ADDR_BITS'(trunc_fix)) & lmask;
    i0        = fast ? i0_fast : i0_lin;
    i1        = (i0 + ADDR_BITS'(1)) & lmask;
  end

  // stage 5 weights
  logic [16:0] w0;
  assign w0 = 17'd65536 - {1'b0, f4_r};

  // stage 7: round half up, saturate; fast mode passes the raw table sample
  logic signed [VW-1:0]          vr;
  logic signed [RW-1:0]          rq;
  logic [RW-SAMPLE_BITS:0]       hi;
  logic signed [SAMPLE_BITS-1:0] res;

  always_comb begin
    vr = gsum6_r + RND;
    rq = vr[VW-1:28];
    hi = rq[RW-1:SAMPLE_BITS-1];
    if ((&hi) || !(|hi)) begin
      res = rq[SAMPLE_BITS-1:0];
    end else if (rq[RW-1]) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    if (fast6_r) begin
      res = t6_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      play1_r <= (in_op == wtip_pkg::OP_PLAY);
      addr1_r <= in_table_addr;
      data1_r <= in_table_data;
      pos1_r  <= in_position;

      play2_r <= play1_r;
      addr2_r <= addr1_r;
      data2_r <= data1_r;
      pos2_r  <= pos1_r;
      prod2_r <= $signed(pos1_r) * $signed({1'b0, spm_r});
      sh2_r   <= $signed({{ADDR_BITS{pos1_r[POS_W-1]}}, pos1_r}) <<< lg;

      play3_r <= play2_r;
      fast3_r <= fast;
      addr3_r <= addr2_r;
      data3_r <= data2_r;
      i0_3_r  <= i0;
      i1_3_r  <= i1;
      f3_r    <= xc[15:0];

      play4_r <= play3_r;
      fast4_r <= fast3_r;
      f4_r    <= f3_r;

      play5_r <= play4_r;
      fast5_r <= fast4_r;
      t5_r    <= t0_4_r;
      m0_5_r  <= $signed(t0_4_r) * $signed({1'b0, w0});
      m1_5_r  <= $signed(t1_4_r) * $signed({2'b0, f4_r});

      play6_r <= play5_r;
      fast6_r <= fast5_r;
      t6_r    <= t5_r;
      gsum6_r <= ($signed({m0_5_r[MW-1], m0_5_r}) + $signed({m1_5_r[MW-1], m1_5_r}))
                 * $signed({1'b0, gain_r});

      out_sample_r <= res;
    end
  end

  // sample table: writes land here in beat order, so later plays see them
  always_ff @(posedge clk) begin
    if (en) begin
      if (v3_r && !play3_r) begin
        mem[addr3_r] <= data3_r;
      end
      t0_4_r <= mem[i0_3_r];
      t1_4_r <= mem[i1_3_r];
    end
  end

endmodule

### hw/rtl/wtip_checker.sv
// ----------------------------------------------------------------------------
// wtip_checker
// Port-level checks of the wavetable player, bound to the top level.
// ----------------------------------------------------------------------------
module wtip_checker #(
  parameter int SAMPLE_BITS = wtip_pkg::SAMPLE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [SAMPLE_BITS-1:0]       out_sample,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [wtip_pkg::PADDR_W-1:0] paddr,
  input logic [wtip_pkg::DATA_W-1:0]  pwdata,
  input logic [wtip_pkg::DATA_W-1:0]  prdata,
  input logic                         pready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("out beat changed while stalled");

  // input side only stalls behind a waiting result
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  // gain write reads back
  a_gain_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[3:2] == wtip_pkg::REG_GAIN)
      ##1 (paddr[3:2] == wtip_pkg::REG_GAIN)
    |-> prdata == {16'b0, $past(pwdata[15:0])})
    else $error("gain register readback mismatch");

  // mode register is two bits wide
  a_mode_rb: assert property (@(posedge clk) disable iff (!rst_n)
    paddr[3:2] == wtip_pkg::REG_MODE |-> prdata[31:2] == 30'b0)
    else $error("mode readback has stray bits");

endmodule

bind wavetable_interp_player wtip_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wtip_checker (.*);
